[sv/apik_pkg.sv]
// Shared constants, types and the arctangent table for the arm position
// inverse kinematics block. No dependencies.
package apik_pkg;

   localparam int IN_W          = 17;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int CORDIC_LAT    = CORDIC_N + 3;

   localparam int ANG_W    = 29;
   localparam int VEC_W    = 26;
   localparam int NORM_MSB = 40;
   localparam int XY_W     = 44;
   localparam int SHIFT_W  = 6;

   localparam int SQ_IN_W   = 50;
   localparam int SQ_OUT_W  = 25;
   localparam int SQ_REM_W  = 26;
   localparam int SQ_STAGES = SQ_OUT_W;

   localparam int Z_OFFSET  = 2656;
   localparam int WR_OFFSET = 450560;
   localparam int LEN_ONE   = 4096;

   localparam logic [50:0] REACH2 = 51'(64'd160000 << 24);

   localparam logic signed [ANG_W-1:0] DEG90      = 29'sd94371840;
   localparam logic signed [ANG_W-1:0] DEG180     = 29'sd188743680;
   localparam logic signed [ANG_W-1:0] ELBOW_BETA = 29'sd77321780;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
      29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
      29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
      29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
      29'sd917,      29'sd458,      29'sd229,      29'sd115,
      29'sd57,       29'sd29,       29'sd14,       29'sd7
   };

   typedef struct packed {
      logic neg_x;
      logic neg_y;
   } quad_type;

endpackage

[sv/arm_position_inverse_kinematics.sv]
// Top level of the arm position inverse kinematics pipeline.
// Depends on apik_pkg, apik_isqrt and apik_cordic.
//
//   channel   ports                               transfer
//   request   start, busy, req_target_*           start high and busy low
//   response  rsp_valid, rsp_status, rsp_*_angle  rsp_valid high, one cycle
//
// A new target is accepted in every cycle; busy is always low.
// The path from a transfer to its result runs through two square root chains
// and one CORDIC chain in series. Reset clears only the valid pipeline. The
// receiver cannot stall, so the pipeline never holds.
module arm_position_inverse_kinematics (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [16:0]  req_target_x,
   input  logic signed [16:0]  req_target_y,
   input  logic signed [16:0]  req_target_z,
   output logic                rsp_valid,
   output logic                rsp_status,
   output logic signed [16:0]  rsp_base_angle,
   output logic signed [17:0]  rsp_shoulder_angle,
   output logic signed [15:0]  rsp_elbow_angle
);
   localparam int SQ     = apik_pkg::SQ_STAGES;
   localparam int LC     = apik_pkg::CORDIC_LAT;
   localparam int AW     = apik_pkg::ANG_W;
   localparam int VW     = apik_pkg::VEC_W;
   localparam int LAT    = 2 * SQ + LC + 8;
   localparam int WZ_D   = SQ + 2;
   localparam int BASE_D = 2 * SQ + 5;
   localparam int SH_D   = SQ + 3;
   localparam int FAR_D  = SQ + LC;

   function automatic logic signed [17:0] round_angle(input logic signed [29:0] v);
      logic [29:0]        mag;
      logic [29:0]        r;
      logic signed [17:0] rounded;
      mag     = v[29] ? 30'(-v) : 30'(v);
      r       = (mag + 30'd2048) >> 12;
      rounded = 18'(r);
      return v[29] ? -rounded : rounded;
   endfunction

   logic [LAT-1:0]              v_ff;
   logic signed [33:0]          x_sq;
   logic signed [33:0]          y_sq;
   logic signed [17:0]          z_off;
   logic signed [16:0]          x1_ff;
   logic signed [16:0]          y1_ff;
   logic [32:0]                 xx_ff;
   logic [32:0]                 yy_ff;
   logic signed [25:0]          wz_ff;
   logic [33:0]                 r2_ff;
   logic [16:0]                 ax;
   logic [16:0]                 ay;
   logic signed [25:0]          wz_dly_ff [WZ_D];
   logic [24:0]                 root_r;
   logic signed [25:0]          wr_diff;
   logic [24:0]                 wr_in;
   logic [24:0]                 wr_ff;
   logic signed [25:0]          wz_t;
   logic [25:0]                 az;
   logic [49:0]                 wr_sq;
   logic [49:0]                 wz_sq;
   logic [49:0]                 wr2_ff;
   logic [49:0]                 wz2_ff;
   logic [50:0]                 d2_ff;
   logic                        far_ff;
   logic [49:0]                 hx_ff;
   logic [49:0]                 hy_ff;
   logic [24:0]                 root_hx;
   logic [24:0]                 root_hy;
   logic signed [AW-1:0]        base_q;
   logic signed [AW-1:0]        sh_q;
   logic signed [AW-1:0]        h_q;
   logic signed [AW-1:0]        base_dly_ff [BASE_D];
   logic signed [AW-1:0]        sh_dly_ff [SH_D];
   logic                        far_dly_ff [FAR_D];
   logic signed [29:0]          base_v_ff;
   logic signed [29:0]          sh_v_ff;
   logic signed [29:0]          el_v_ff;
   logic                        far_v_ff;
   logic signed [17:0]          base_r;
   logic signed [17:0]          sh_r;
   logic signed [17:0]          el_r;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[LAT-2:0], start && !busy};
      end
   end

   assign x_sq  = req_target_x * req_target_x;
   assign y_sq  = req_target_y * req_target_y;
   assign z_off = 18'(req_target_z) - 18'(apik_pkg::Z_OFFSET);

   always_ff @(posedge clock) begin
      x1_ff <= req_target_x;
      y1_ff <= req_target_y;
      xx_ff <= x_sq[32:0];
      yy_ff <= y_sq[32:0];
      wz_ff <= {z_off, 8'd0};
      r2_ff <= 34'(xx_ff) + 34'(yy_ff);
      wz_dly_ff[0] <= wz_ff;
      for (int k = 1; k < WZ_D; k++) begin
         wz_dly_ff[k] <= wz_dly_ff[k-1];
      end
   end

   assign ax = x1_ff[16] ? 17'(-x1_ff) : 17'(x1_ff);
   assign ay = y1_ff[16] ? 17'(-y1_ff) : 17'(y1_ff);

   apik_cordic u_base_cordic (
      .clock (clock),
      .vec_x (VW'(ax)),
      .vec_y (VW'(ay)),
      .quad  ({x1_ff[16], y1_ff[16]}),
      .angle (base_q)
   );

   apik_isqrt u_radial_sqrt (
      .clock    (clock),
      .radicand ({r2_ff, 16'd0}),
      .root     (root_r)
   );

   assign wr_diff = $signed({1'b0, root_r}) - 26'(apik_pkg::WR_OFFSET);
   assign wr_in   = (wr_diff < 26'(apik_pkg::LEN_ONE)) ? 25'(apik_pkg::LEN_ONE)
                                                       : wr_diff[24:0];
   assign wz_t    = wz_dly_ff[WZ_D-1];
   assign az      = wz_t[25] ? 26'(-wz_t) : 26'(wz_t);
   assign wr_sq   = wr_ff * wr_ff;
   assign wz_sq   = az[24:0] * az[24:0];

   always_ff @(posedge clock) begin
      wr_ff  <= wr_in;
      wr2_ff <= wr_sq;
      wz2_ff <= wz_sq;
      d2_ff  <= 51'(wr2_ff) + 51'(wz2_ff);
      far_ff <= (d2_ff > apik_pkg::REACH2);
      hx_ff  <= d2_ff[49:0];
      hy_ff  <= 50'(apik_pkg::REACH2 - d2_ff);
   end

   apik_cordic u_shoulder_cordic (
      .clock (clock),
      .vec_x (VW'(wr_ff)),
      .vec_y (az),
      .quad  ({1'b0, wz_t[25]}),
      .angle (sh_q)
   );

   apik_isqrt u_reach_sqrt (
      .clock    (clock),
      .radicand (hx_ff),
      .root     (root_hx)
   );

   apik_isqrt u_slack_sqrt (
      .clock    (clock),
      .radicand (hy_ff),
      .root     (root_hy)
   );

   apik_cordic u_half_cordic (
      .clock (clock),
      .vec_x (VW'(root_hx)),
      .vec_y (VW'(root_hy)),
      .quad  ({1'b0, 1'b0}),
      .angle (h_q)
   );

   always_ff @(posedge clock) begin
      base_dly_ff[0] <= base_q;
      for (int k = 1; k < BASE_D; k++) begin
         base_dly_ff[k] <= base_dly_ff[k-1];
      end
      sh_dly_ff[0] <= sh_q;
      for (int k = 1; k < SH_D; k++) begin
         sh_dly_ff[k] <= sh_dly_ff[k-1];
      end
      far_dly_ff[0] <= far_ff;
      for (int k = 1; k < FAR_D; k++) begin
         far_dly_ff[k] <= far_dly_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      base_v_ff <= 30'(base_dly_ff[BASE_D-1]);
      sh_v_ff   <= 30'(sh_dly_ff[SH_D-1]) - 30'(h_q);
      el_v_ff   <= (30'(h_q) <<< 1) - 30'(apik_pkg::ELBOW_BETA);
      far_v_ff  <= far_dly_ff[FAR_D-1];
   end

   assign base_r = round_angle(base_v_ff);
   assign sh_r   = round_angle(sh_v_ff);
   assign el_r   = round_angle(el_v_ff);

   always_ff @(posedge clock) begin
      rsp_status         <= far_v_ff;
      rsp_base_angle     <= far_v_ff ? '0 : base_r[16:0];
      rsp_shoulder_angle <= far_v_ff ? '0 : sh_r;
      rsp_elbow_angle    <= far_v_ff ? '0 : el_r[15:0];
   end

   assign rsp_valid = v_ff[LAT-1];

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(LAT) rsp_valid)
      else $error("transfer did not produce a result at the pipeline depth");

   a_unreach_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_base_angle == '0 &&
                                  rsp_shoulder_angle == '0 && rsp_elbow_angle == '0)
      else $error("unreachable target with non-zero angles");

   a_base_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_base_angle >= -17'sd46080 &&
                                   rsp_base_angle <= 17'sd46080)
      else $error("base angle outside half a turn");

endmodule

[sv/apik_isqrt.sv]
// Pipelined integer square root, two radicand bits per stage.
// Depends on apik_pkg.
module apik_isqrt (
   input  logic                           clock,
   input  logic [apik_pkg::SQ_IN_W-1:0]   radicand,
   output logic [apik_pkg::SQ_OUT_W-1:0]  root
);
   localparam int N  = apik_pkg::SQ_STAGES;
   localparam int IW = apik_pkg::SQ_IN_W;
   localparam int OW = apik_pkg::SQ_OUT_W;
   localparam int RW = apik_pkg::SQ_REM_W;

   logic [IW-1:0] val_ff  [N];
   logic [OW-1:0] root_ff [N];
   logic [RW-1:0] rem_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [IW-1:0]   val_prev;
      logic [OW-1:0]   root_prev;
      logic [RW-1:0]   rem_prev;
      logic [RW+1:0]   cur;
      logic [RW+1:0]   trial;
      logic            ge;
      if (k == 0) begin : g_first
         assign val_prev  = radicand;
         assign root_prev = '0;
         assign rem_prev  = '0;
      end else begin : g_next
         assign val_prev  = val_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
      end
      assign cur   = {rem_prev, val_prev[IW-1 -: 2]};
      assign trial = (RW+2)'({root_prev, 2'b01});
      assign ge    = (cur >= trial);
      always_ff @(posedge clock) begin
         val_ff[k]  <= {val_prev[IW-3:0], 2'b00};
         root_ff[k] <= {root_prev[OW-2:0], ge};
         rem_ff[k]  <= ge ? RW'(cur - trial) : RW'(cur);
      end
   end

   assign root = root_ff[N-1];

endmodule

[sv/apik_cordic.sv]
// Pipelined CORDIC vectoring unit with operand normalisation, first-quadrant
// clamp and quadrant mirroring. Depends on apik_pkg.
module apik_cordic (
   input  logic                                clock,
   input  logic [apik_pkg::VEC_W-1:0]          vec_x,
   input  logic [apik_pkg::VEC_W-1:0]          vec_y,
   input  apik_pkg::quad_type                  quad,
   output logic signed [apik_pkg::ANG_W-1:0]   angle
);
   localparam int N  = apik_pkg::CORDIC_N;
   localparam int VW = apik_pkg::VEC_W;
   localparam int NW = apik_pkg::NORM_MSB + 1;
   localparam int XW = apik_pkg::XY_W;
   localparam int AW = apik_pkg::ANG_W;
   localparam int SW = apik_pkg::SHIFT_W;

   logic [VW-1:0]          orv;
   logic [SW-1:0]          shift_in;
   logic [VW-1:0]          nx_ff;
   logic [VW-1:0]          ny_ff;
   logic [SW-1:0]          shift_ff;
   apik_pkg::quad_type     quad_ff [N+2];
   logic                   zero_ff [N+2];
   logic signed [XW-1:0]   cx_ff [N+1];
   logic signed [XW-1:0]   cy_ff [N+1];
   logic signed [AW-1:0]   cz_ff [N+1];
   logic signed [AW-1:0]   q;
   logic signed [AW-1:0]   angle_ff;

   assign orv = vec_x | vec_y;

   always_comb begin
      shift_in = SW'(apik_pkg::NORM_MSB);
      for (int b = 0; b < VW; b++) begin
         if (orv[b]) begin
            shift_in = SW'(apik_pkg::NORM_MSB - b);
         end
      end
   end

   always_ff @(posedge clock) begin
      nx_ff      <= vec_x;
      ny_ff      <= vec_y;
      shift_ff   <= shift_in;
      quad_ff[0] <= quad;
      zero_ff[0] <= (orv == '0);
      cx_ff[0]   <= XW'(NW'(nx_ff) << shift_ff);
      cy_ff[0]   <= XW'(NW'(ny_ff) << shift_ff);
      cz_ff[0]   <= '0;
      for (int k = 1; k < N + 2; k++) begin
         quad_ff[k] <= quad_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (!cy_ff[i][XW-1]) begin
            cx_ff[i+1] <= cx_ff[i] + dx;
            cy_ff[i+1] <= cy_ff[i] - dy;
            cz_ff[i+1] <= cz_ff[i] + apik_pkg::ATAN_TAB[i];
         end else begin
            cx_ff[i+1] <= cx_ff[i] - dx;
            cy_ff[i+1] <= cy_ff[i] + dy;
            cz_ff[i+1] <= cz_ff[i] - apik_pkg::ATAN_TAB[i];
         end
      end
   end

   always_comb begin
      q = cz_ff[N];
      if (q < 0) begin
         q = '0;
      end else if (q > apik_pkg::DEG90) begin
         q = apik_pkg::DEG90;
      end
      if (zero_ff[N+1]) begin
         q = '0;
      end
      if (quad_ff[N+1].neg_x) begin
         q = apik_pkg::DEG180 - q;
      end
      if (quad_ff[N+1].neg_y) begin
         q = -q;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= q;
   end

   assign angle = angle_ff;

endmodule

[tb/arm_position_inverse_kinematics_tb.sv]
// Self-checking testbench for the arm position inverse kinematics pipeline.
// Depends on apik_pkg and arm_position_inverse_kinematics; a scoreboard class
// predicts each joint solution and compares it with the response stream.
module arm_position_inverse_kinematics_tb;

   typedef struct {
      logic                status;
      logic signed [16:0]  base;
      logic signed [17:0]  shoulder;
      logic signed [15:0]  elbow;
   } joint_solution_type;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint quadrant_angle(longint unsigned ax, longint unsigned ay);
      longint x, y, z, dx, dy;
      z = 0;
      if (ax == 0 && ay == 0) return 0;
      while ((ax | ay) < (64'd1 << apik_pkg::NORM_MSB)) begin
         ax = ax << 1;
         ay = ay << 1;
      end
      x = longint'(ax);
      y = longint'(ay);
      for (int i = 0; i < apik_pkg::CORDIC_N; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(apik_pkg::ATAN_TAB[i]);
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(apik_pkg::ATAN_TAB[i]);
         end
      end
      if (z < 0) z = 0;
      if (z > longint'(apik_pkg::DEG90)) z = longint'(apik_pkg::DEG90);
      return z;
   endfunction

   function automatic longint full_angle(longint y, longint x);
      longint q;
      q = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
      if (x < 0) q = longint'(apik_pkg::DEG180) - q;
      if (y < 0) q = -q;
      return q;
   endfunction

   function automatic longint to_deg256(longint v);
      if (v >= 0) return (v + 2048) >>> 12;
      return -((-v + 2048) >>> 12);
   endfunction

   function automatic joint_solution_type solve_joints(longint x, longint y, longint z);
      joint_solution_type s;
      longint unsigned d2, reach2;
      longint wr, wz, h;
      reach2 = 64'd160000 << 24;
      wr = longint'(int_sqrt(longint'(x * x + y * y) << 16)) - apik_pkg::WR_OFFSET;
      wz = (z - apik_pkg::Z_OFFSET) * 256;
      if (wr < apik_pkg::LEN_ONE) wr = apik_pkg::LEN_ONE;
      d2 = wr * wr + wz * wz;
      s = '{1'b0, '0, '0, '0};
      if (d2 > reach2) begin
         s.status = 1'b1;
         return s;
      end
      h = quadrant_angle(int_sqrt(d2), int_sqrt(reach2 - d2));
      s.base     = 17'(to_deg256(full_angle(y, x)));
      s.shoulder = 18'(to_deg256(full_angle(wz, wr) - h));
      s.elbow    = 16'(to_deg256(2 * h - longint'(apik_pkg::ELBOW_BETA)));
      return s;
   endfunction

   class joint_scoreboard;
      joint_solution_type pending[$];
      int errors = 0;

      function void note_target(longint x, longint y, longint z);
         pending.push_back(solve_joints(x, y, z));
      endfunction

      function void check_solution(logic st, logic signed [16:0] b,
                                   logic signed [17:0] sh, logic signed [15:0] el);
         joint_solution_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response status %0d base %0d", $time, st, b);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (b !== e.base) begin
            $display("%0t: base expected %0d actual %0d", $time, e.base, b);
            errors++;
         end
         if (sh !== e.shoulder) begin
            $display("%0t: shoulder expected %0d actual %0d", $time, e.shoulder, sh);
            errors++;
         end
         if (el !== e.elbow) begin
            $display("%0t: elbow expected %0d actual %0d", $time, e.elbow, el);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [16:0] req_target_x = '0;
   logic signed [16:0] req_target_y = '0;
   logic signed [16:0] req_target_z = '0;
   logic               rsp_valid;
   logic               rsp_status;
   logic signed [16:0] rsp_base_angle;
   logic signed [17:0] rsp_shoulder_angle;
   logic signed [15:0] rsp_elbow_angle;

   joint_scoreboard board = new();
   int accepted = 0;
   int quiet_cycles = 0;
   bit allow_idle = 1'b1;

   arm_position_inverse_kinematics uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_base_angle(rsp_base_angle), .rsp_shoulder_angle(rsp_shoulder_angle),
      .rsp_elbow_angle(rsp_elbow_angle)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (start && !busy) begin
            board.note_target(req_target_x, req_target_y, req_target_z);
            accepted <= accepted + 1;
         end
         if (rsp_valid) begin
            board.check_solution(rsp_status, rsp_base_angle, rsp_shoulder_angle,
                                 rsp_elbow_angle);
         end
         if (quiet_cycles > 3000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_target(int x, int y, int z);
      int seen;
      while (allow_idle && $urandom_range(99) < 17) begin
         start <= 1'b0;
         @(negedge clock);
      end
      seen = accepted;
      start <= 1'b1;
      req_target_x <= 17'(x);
      req_target_y <= 17'(y);
      req_target_z <= 17'(z);
      do @(negedge clock); while (accepted == seen);
   endtask

   task automatic send_random_target();
      if ($urandom_range(99) < 75) begin
         send_target($urandom_range(16400) - 8200, $urandom_range(16400) - 8200,
                     $urandom_range(13200) - 4000);
      end else begin
         send_target($urandom_range(131071) - 65536, $urandom_range(131071) - 65536,
                     $urandom_range(131071) - 65536);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_target(0, 0, 0);
      send_target(0, 0, 2656);
      send_target(-3000, 0, 2656);
      send_target(3000, 0, 2656);
      send_target(0, 3000, 4000);
      send_target(0, -3000, 1000);
      send_target(-3000, -2000, 3000);
      send_target(1760, 0, 9056);
      send_target(8160, 0, 2656);
      send_target(8161, 0, 2656);
      send_target(65535, 65535, 65535);
      send_target(-65536, -65536, -65536);
      send_target(-65536, 0, 0);
      send_target(65535, 0, 0);
      send_target(1, -1, -65536);
      send_target(-1, 1, 65535);
      send_target(1760, 1, 2656);
      send_target(2000, 2000, -3744);
      for (int n = 0; n < 1050; n++) begin
         allow_idle = (n < 300 || n >= 500);
         send_random_target();
      end
      start <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
